/* design/sidv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidv_pkg
// Shared types and constants of the identification verifier.
// ----------------------------------------------------------------------------
package sidv_pkg;

  localparam int WIDTH = 32;
  localparam int NW    = WIDTH + 1;
  localparam int CNT_W = $clog2(WIDTH);
  localparam int FLD_W = 32;

  typedef enum logic [1:0] {
    REG_MODULUS   = 2'd0,
    REG_GENERATOR = 2'd1,
    REG_PUBLIC    = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED0,
    S_RED1,
    S_SQ,
    S_MUL,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [FLD_W-1:0] commitment;
    logic [FLD_W-1:0] challenge;
    logic [FLD_W-1:0] response;
  } in_t;

  typedef struct packed {
    logic [FLD_W-1:0] left_value;
    logic [FLD_W-1:0] right_value;
    logic             accepted;
  } out_t;

endpackage

/* design/schnorr_identification_verify_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schnorr_identification_verify_core
// Checks g^z mod N against (Y * X^c) mod N with two bit-serial multipliers.
//
//   channel | direction | handshake           | beat
//   in      | input     | in_valid / in_stall | commitment, challenge, response
//   out     | output    | out_valid/out_stall | left_value, right_value, accepted
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// An item takes 67 multiplies on the one-bit-per-cycle multipliers (start, WIDTH steps,
// done): two reductions, WIDTH squarings, WIDTH multiplies and one final product.
// Reset clears the sequencer and output valid; registers return to N=2, g=0, X=0.
// A result waits in the output register under stall; the next beat is taken
// once the sequencer is back in idle.
// ----------------------------------------------------------------------------
module schnorr_identification_verify_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  sidv_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output sidv_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [sidv_pkg::FLD_W-1:0] cfg_data
);
  import sidv_pkg::*;

  state_t           state;
  state_t           state_next;
  logic             kick;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] generator;
  logic [WIDTH-1:0] public_value;
  logic [WIDTH-1:0] y;
  logic [WIDTH-1:0] c;
  logic [WIDTH-1:0] z;
  logic [WIDTH-1:0] gr;
  logic [WIDTH-1:0] xr;
  logic [WIDTH-1:0] yr;
  logic [WIDTH-1:0] accl;
  logic [WIDTH-1:0] accr;
  logic [CNT_W-1:0] idx;
  logic [NW-1:0]    n;
  logic [WIDTH-1:0] one;
  logic [WIDTH-1:0] a_mcand;
  logic [WIDTH-1:0] a_mplier;
  logic [WIDTH-1:0] b_mcand;
  logic [WIDTH-1:0] b_mplier;
  logic [WIDTH-1:0] a_res;
  logic [WIDTH-1:0] b_res;
  logic             a_done;
  logic             b_done;
  logic             out_free;

  assign n        = (modulus == '0) ? (NW'(1) << WIDTH) : {1'b0, modulus};
  assign one      = (n == NW'(1)) ? '0 : WIDTH'(1);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus      <= WIDTH'(2);
      generator    <= '0;
      public_value <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS:   modulus      <= cfg_data[WIDTH-1:0];
        REG_GENERATOR: generator    <= cfg_data[WIDTH-1:0];
        REG_PUBLIC:    public_value <= cfg_data[WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_RED0;
      S_RED0: if (a_done) state_next = S_RED1;
      S_RED1: if (a_done) state_next = S_SQ;
      S_SQ:   if (a_done) state_next = S_MUL;
      S_MUL:  if (a_done) state_next = (idx == '0) ? S_FIN : S_SQ;
      S_FIN:  if (a_done) state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // operand select
  always_comb begin
    a_mcand  = one;
    a_mplier = accl;
    b_mcand  = one;
    b_mplier = accr;
    case (state)
      S_RED0: begin
        a_mplier = generator;
        b_mplier = public_value;
      end
      S_RED1: begin
        a_mplier = y;
        b_mplier = y;
      end
      S_SQ: begin
        a_mcand = accl;
        b_mcand = accr;
      end
      S_MUL: begin
        a_mcand = z[idx] ? gr : one;
        b_mcand = c[idx] ? xr : one;
      end
      S_FIN: begin
        b_mcand = yr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kick      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      kick  <= (state_next != state) && (state_next inside {S_RED0, S_RED1, S_SQ, S_MUL, S_FIN});
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (in_valid) begin
        y <= in_data.commitment[WIDTH-1:0];
        c <= in_data.challenge[WIDTH-1:0];
        z <= in_data.response[WIDTH-1:0];
      end
      S_RED0: if (a_done) begin
        gr   <= a_res;
        xr   <= b_res;
        accl <= one;
        accr <= one;
        idx  <= CNT_W'(WIDTH - 1);
      end
      S_RED1: if (a_done) yr <= a_res;
      S_SQ: if (a_done) begin
        accl <= a_res;
        accr <= b_res;
      end
      S_MUL: if (a_done) begin
        accl <= a_res;
        accr <= b_res;
        idx  <= idx - 1'b1;
      end
      S_FIN: if (a_done) accr <= b_res;
      S_OUT: if (out_free) begin
        out_data.left_value  <= FLD_W'(accl);
        out_data.right_value <= FLD_W'(accr);
        out_data.accepted    <= (accl == accr);
      end
      default: ;
    endcase
  end

  sidv_mulmod u_mul_a (
    .clk    (clk),
    .rst    (rst),
    .start  (kick),
    .n      (n),
    .mcand  (a_mcand),
    .mplier (a_mplier),
    .result (a_res),
    .done   (a_done)
  );

  sidv_mulmod u_mul_b (
    .clk    (clk),
    .rst    (rst),
    .start  (kick),
    .n      (n),
    .mcand  (b_mcand),
    .mplier (b_mplier),
    .result (b_res),
    .done   (b_done)
  );

  a_lockstep: assert property (@(posedge clk) disable iff (rst) a_done == b_done)
    else $error("multipliers out of step");
  a_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.accepted == (out_data.left_value == out_data.right_value))
    else $error("accept flag disagrees with values");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (a_done && state == S_IDLE) |-> 1'b0)
    else $error("multiplier finished while idle");
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> ({1'b0, accl} < n && {1'b0, accr} < n))
    else $error("result not reduced");

endmodule

/* design/sidv_mulmod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidv_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first,
// doubling and adding with a conditional subtract of the modulus after each.
// ----------------------------------------------------------------------------
module sidv_mulmod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sidv_pkg::NW-1:0]    n,
  input  logic [sidv_pkg::WIDTH-1:0] mcand,
  input  logic [sidv_pkg::WIDTH-1:0] mplier,
  output logic [sidv_pkg::WIDTH-1:0] result,
  output logic                       done
);
  import sidv_pkg::*;

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] m;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [NW:0]      d;
  logic [NW:0]      d1;
  logic [NW:0]      s;
  logic [NW:0]      s1;

  always_comb begin
    d  = {1'b0, acc, 1'b0};
    d1 = (d >= {1'b0, n}) ? d - {1'b0, n} : d;
    s  = d1 + (m[WIDTH-1] ? {2'b00, a} : '0);
    s1 = (s >= {1'b0, n}) ? s - {1'b0, n} : s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      a   <= mcand;
      m   <= mplier;
    end else if (busy) begin
      acc <= s1[WIDTH-1:0];
      m   <= {m[WIDTH-2:0], 1'b0};
    end
  end

  assign result = acc;

endmodule
